FILE: src/upgradable_rw_lock_table_defines.svh
// ----------------------------------------------------------------------------
// Upgradable reader/writer lock table - assertion macros
// Implication checks on the rising clock, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef UPGRADABLE_RW_LOCK_TABLE_DEFINES_SVH
`define UPGRADABLE_RW_LOCK_TABLE_DEFINES_SVH

`ifndef SYNTH
`define URWL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("urwl assertion failed");
`define URWL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("urwl assertion failed");
`else
`define URWL_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define URWL_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: src/urwl_pkg.sv
// ----------------------------------------------------------------------------
// Upgradable reader/writer lock table - package
// Field widths, operation and status codes, controller types.
// ----------------------------------------------------------------------------
package urwl_pkg;

  localparam int OP_W     = 2;
  localparam int IDX_W    = 4;
  localparam int REQ_W    = 4;
  localparam int STATUS_W = 3;
  localparam int MODE_W   = 2;
  localparam int COUNT_W  = 4;
  localparam int WAKE_W   = 2;

  typedef enum logic [OP_W-1:0] {
    OP_READ    = 2'd0,
    OP_INTENT  = 2'd1,
    OP_UPGRADE = 2'd2,
    OP_UNLOCK  = 2'd3
  } op_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_FREE   = 2'd0,
    MODE_READ   = 2'd1,
    MODE_INTENT = 2'd2,
    MODE_WRITE  = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_RETRY     = 3'd1,
    ST_NOT_OWNER = 3'd2,
    ST_NOT_HELD  = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_e;

  typedef enum logic [WAKE_W-1:0] {
    WAKE_NONE = 2'd0,
    WAKE_ONE  = 2'd1,
    WAKE_ALL  = 2'd2
  } wake_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_e;

  typedef struct packed {
    logic clr_step;
    logic req_load;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
  } dp_status_t;

endpackage

FILE: src/urwl_datapath.sv
// ----------------------------------------------------------------------------
// Upgradable reader/writer lock table - datapath
// Lock entry memory, request registers, update logic and result register.
// ----------------------------------------------------------------------------
module urwl_datapath #(
  parameter int NUM_LOCKS   = 16,
  parameter int MAX_READERS = 15
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  urwl_pkg::ctrl_cmd_t           cmd_i,
  output urwl_pkg::dp_status_t          stat_o,
  input  logic [urwl_pkg::OP_W-1:0]     op_i,
  input  logic [urwl_pkg::IDX_W-1:0]    lock_index_i,
  input  logic [urwl_pkg::REQ_W-1:0]    requester_id_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [urwl_pkg::STATUS_W-1:0] status_o,
  output logic [urwl_pkg::MODE_W-1:0]   lock_mode_o,
  output logic [urwl_pkg::COUNT_W-1:0]  reader_count_o,
  output logic [urwl_pkg::WAKE_W-1:0]   wake_o
);

  localparam int AW = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
  localparam int IW = (AW > urwl_pkg::IDX_W) ? AW : urwl_pkg::IDX_W;
  localparam int RW = $clog2(MAX_READERS + 1);
  localparam int CW = (RW > urwl_pkg::COUNT_W) ? RW : urwl_pkg::COUNT_W;

  urwl_pkg::mode_e            mode_mem [NUM_LOCKS];
  logic [RW-1:0]              rd_mem   [NUM_LOCKS];
  logic [urwl_pkg::REQ_W-1:0] own_mem  [NUM_LOCKS];

  logic [AW-1:0]              clr_cnt_q;
  logic [IW-1:0]              idx_ext;
  logic                       in_range;
  logic [AW-1:0]              raddr;

  urwl_pkg::op_e              op_q;
  logic [AW-1:0]              addr_q;
  logic [urwl_pkg::REQ_W-1:0] req_q;
  logic                       in_range_q;
  urwl_pkg::mode_e            mode_q;
  logic [RW-1:0]              rd_q;
  logic [urwl_pkg::REQ_W-1:0] own_q;

  urwl_pkg::mode_e            mode_nx;
  logic [RW-1:0]              rd_nx;
  logic [urwl_pkg::REQ_W-1:0] own_nx;
  urwl_pkg::status_e          st_nx;
  urwl_pkg::wake_e            wake_nx;
  logic [CW-1:0]              cnt_ext;

  logic                       we;
  logic [AW-1:0]              waddr;

  logic                       out_valid_q;
  urwl_pkg::status_e          status_q;
  urwl_pkg::mode_e            mode_out_q;
  logic [urwl_pkg::COUNT_W-1:0] count_q;
  urwl_pkg::wake_e            wake_q;

  assign idx_ext  = IW'(lock_index_i);
  assign in_range = (32'(lock_index_i) < NUM_LOCKS);
  assign raddr    = in_range ? idx_ext[AW-1:0] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
    end
  end

  assign stat_o.clr_last = (clr_cnt_q == AW'(NUM_LOCKS - 1));
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      op_q       <= urwl_pkg::op_e'(op_i);
      addr_q     <= raddr;
      req_q      <= requester_id_i;
      in_range_q <= in_range;
      mode_q     <= mode_mem[raddr];
      rd_q       <= rd_mem[raddr];
      own_q      <= own_mem[raddr];
    end
  end

  always_comb begin
    mode_nx = mode_q;
    rd_nx   = rd_q;
    own_nx  = own_q;
    st_nx   = urwl_pkg::ST_OK;
    wake_nx = urwl_pkg::WAKE_NONE;
    case (op_q)
      urwl_pkg::OP_READ: begin
        if (mode_q == urwl_pkg::MODE_WRITE) begin
          st_nx = urwl_pkg::ST_RETRY;
        end else if (rd_q >= RW'(MAX_READERS)) begin
          st_nx = urwl_pkg::ST_OVERFLOW;
        end else begin
          rd_nx = rd_q + RW'(1);
          if (mode_q == urwl_pkg::MODE_FREE) mode_nx = urwl_pkg::MODE_READ;
        end
      end
      urwl_pkg::OP_INTENT: begin
        if (mode_q == urwl_pkg::MODE_WRITE || mode_q == urwl_pkg::MODE_INTENT) begin
          st_nx = urwl_pkg::ST_RETRY;
        end else if (rd_q >= RW'(MAX_READERS)) begin
          st_nx = urwl_pkg::ST_OVERFLOW;
        end else begin
          rd_nx   = rd_q + RW'(1);
          mode_nx = urwl_pkg::MODE_INTENT;
          own_nx  = req_q;
        end
      end
      urwl_pkg::OP_UPGRADE: begin
        if (mode_q != urwl_pkg::MODE_INTENT) begin
          st_nx = urwl_pkg::ST_NOT_HELD;
        end else if (own_q != req_q) begin
          st_nx = urwl_pkg::ST_NOT_OWNER;
        end else if (rd_q > RW'(1)) begin
          st_nx = urwl_pkg::ST_RETRY;
        end else begin
          rd_nx   = '0;
          mode_nx = urwl_pkg::MODE_WRITE;
        end
      end
      urwl_pkg::OP_UNLOCK: begin
        case (mode_q)
          urwl_pkg::MODE_FREE: begin
            st_nx = urwl_pkg::ST_NOT_HELD;
          end
          urwl_pkg::MODE_READ: begin
            if (rd_q > RW'(1)) begin
              rd_nx = rd_q - RW'(1);
            end else begin
              rd_nx   = '0;
              mode_nx = urwl_pkg::MODE_FREE;
              wake_nx = urwl_pkg::WAKE_ONE;
            end
          end
          urwl_pkg::MODE_INTENT: begin
            if (rd_q > RW'(1)) begin
              rd_nx = rd_q - RW'(1);
              if (own_q == req_q) mode_nx = urwl_pkg::MODE_READ;
            end else begin
              rd_nx   = '0;
              mode_nx = urwl_pkg::MODE_FREE;
              wake_nx = urwl_pkg::WAKE_ALL;
            end
          end
          default: begin
            if (own_q != req_q) begin
              st_nx = urwl_pkg::ST_NOT_OWNER;
            end else begin
              rd_nx   = '0;
              mode_nx = urwl_pkg::MODE_FREE;
              wake_nx = urwl_pkg::WAKE_ALL;
            end
          end
        endcase
      end
      default: begin
        st_nx = urwl_pkg::ST_NOT_HELD;
      end
    endcase
    if (!in_range_q) begin
      st_nx   = urwl_pkg::ST_NOT_HELD;
      mode_nx = urwl_pkg::MODE_FREE;
      rd_nx   = '0;
      wake_nx = urwl_pkg::WAKE_NONE;
    end
  end

  assign cnt_ext = CW'(rd_nx);

  // clearing pass owns the write port until it ends
  assign we    = cmd_i.clr_step || (cmd_i.commit && in_range_q);
  assign waddr = cmd_i.clr_step ? clr_cnt_q : addr_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mode_mem[waddr] <= cmd_i.clr_step ? urwl_pkg::MODE_FREE : mode_nx;
      rd_mem[waddr]   <= cmd_i.clr_step ? '0 : rd_nx;
      own_mem[waddr]  <= cmd_i.clr_step ? '0 : own_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q   <= st_nx;
      mode_out_q <= mode_nx;
      count_q    <= cnt_ext[urwl_pkg::COUNT_W-1:0];
      wake_q     <= wake_nx;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign lock_mode_o    = mode_out_q;
  assign reader_count_o = count_q;
  assign wake_o         = wake_q;

endmodule

FILE: src/urwl_ctrl.sv
// ----------------------------------------------------------------------------
// Upgradable reader/writer lock table - controller
// Sequences the clearing pass, request capture and entry update.
// ----------------------------------------------------------------------------
module urwl_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  urwl_pkg::dp_status_t stat_i,
  output urwl_pkg::ctrl_cmd_t  cmd_o
);

  urwl_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= urwl_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      urwl_pkg::S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) state_d = urwl_pkg::S_IDLE;
      end
      urwl_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.req_load = 1'b1;
          state_d        = urwl_pkg::S_EXEC;
        end
      end
      urwl_pkg::S_EXEC: begin
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = urwl_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = urwl_pkg::S_IDLE;
      end
    endcase
  end

endmodule

FILE: src/upgradable_rw_lock_table.sv
// ----------------------------------------------------------------------------
// Upgradable reader/writer lock table - top level
// Table of reader/writer locks with upgrade intent, one request per beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: op, lock_index, requester_id; a beat is taken when
//   in_valid_i is high and in_stall_o is low.
//   Output channel: status, lock_mode, reader_count, wake; one result beat
//   per request, taken when out_valid_o is high and out_stall_i is low.
//   The request is registered with its entry; the result is then written
//   to the output register once that register is free. A new request is
//   taken only after the current one commits: read, then update and write.
//   A finished result sits in the output register while the next request
//   is read; when the receiver stalls, the update of that next request waits
//   until the output register frees, and the input stalls meanwhile.
//   Reset: after rst_ni rises, a clearing pass of NUM_LOCKS cycles sets every
//   lock free with zero readers; in_stall_o stays high during it.
//   A lock_index of NUM_LOCKS or more reports not held and changes nothing.
// ----------------------------------------------------------------------------
`include "upgradable_rw_lock_table_defines.svh"

module upgradable_rw_lock_table #(
  parameter int NUM_LOCKS   = 16,
  parameter int MAX_READERS = 15
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [urwl_pkg::OP_W-1:0]     op_i,
  input  logic [urwl_pkg::IDX_W-1:0]    lock_index_i,
  input  logic [urwl_pkg::REQ_W-1:0]    requester_id_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [urwl_pkg::STATUS_W-1:0] status_o,
  output logic [urwl_pkg::MODE_W-1:0]   lock_mode_o,
  output logic [urwl_pkg::COUNT_W-1:0]  reader_count_o,
  output logic [urwl_pkg::WAKE_W-1:0]   wake_o
);

  urwl_pkg::ctrl_cmd_t  cmd;
  urwl_pkg::dp_status_t stat;

  urwl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  urwl_datapath #(
    .NUM_LOCKS   (NUM_LOCKS),
    .MAX_READERS (MAX_READERS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .op_i           (op_i),
    .lock_index_i   (lock_index_i),
    .requester_id_i (requester_id_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .status_o       (status_o),
    .lock_mode_o    (lock_mode_o),
    .reader_count_o (reader_count_o),
    .wake_o         (wake_o)
  );

  `URWL_ASSERT_NXT(a_accept_then_busy, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `URWL_ASSERT_IMP(a_no_result_overrun, clk_i, rst_ni, cmd.commit, !(out_valid_o && out_stall_i))
  `URWL_ASSERT_IMP(a_wake_frees_lock, clk_i, rst_ni, out_valid_o && (wake_o != urwl_pkg::WAKE_NONE), lock_mode_o == urwl_pkg::MODE_FREE)
  `URWL_ASSERT_IMP(a_one_action, clk_i, rst_ni, 1'b1, $onehot0({cmd.clr_step, cmd.req_load, cmd.commit}))

endmodule

FILE: verif/tb_upgradable_rw_lock_table.sv
// ----------------------------------------------------------------------------
// Upgradable reader/writer lock table - testbench
// Drives lock requests through the valid/stall input channel with random
// gaps and one long output hold-off. A shadow copy of the lock table predicts
// every reply, and each reply beat is checked field by field in order.
// ----------------------------------------------------------------------------
module tb_upgradable_rw_lock_table;
  timeunit 1ns;
  timeprecision 1ps;

  import urwl_pkg::*;

  localparam int LOCK_COUNT  = 16;
  localparam int READER_CAP  = 15;
  localparam int ITEM_TARGET = 1625;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    status_e             status;
    mode_e               mode;
    logic [COUNT_W-1:0]  count;
    wake_e               wake;
  } lock_reply_t;

  class lock_table_shadow;
    mode_e       mode_q    [LOCK_COUNT];
    int          readers_q [LOCK_COUNT];
    logic [3:0]  owner_q   [LOCK_COUNT];
    lock_reply_t reply_q[$];
    int          mismatches;
    int          replies_seen;

    function new();
      foreach (mode_q[i]) begin
        mode_q[i]    = MODE_FREE;
        readers_q[i] = 0;
        owner_q[i]   = '0;
      end
      mismatches   = 0;
      replies_seen = 0;
    endfunction

    function int pending();
      return reply_q.size();
    endfunction

    function void accept_request(op_e op, logic [IDX_W-1:0] idx, logic [REQ_W-1:0] req);
      lock_reply_t r;
      mode_e       m;
      int          rd;
      r.status = ST_OK;
      r.wake   = WAKE_NONE;
      if (int'(idx) >= LOCK_COUNT) begin
        r.status = ST_NOT_HELD;
        r.mode   = MODE_FREE;
        r.count  = '0;
        reply_q.push_back(r);
        return;
      end
      m  = mode_q[idx];
      rd = readers_q[idx];
      case (op)
        OP_READ: begin
          if (m == MODE_WRITE) r.status = ST_RETRY;
          else if (rd >= READER_CAP) r.status = ST_OVERFLOW;
          else begin
            rd++;
            if (m == MODE_FREE) m = MODE_READ;
          end
        end
        OP_INTENT: begin
          if (m == MODE_WRITE || m == MODE_INTENT) r.status = ST_RETRY;
          else if (rd >= READER_CAP) r.status = ST_OVERFLOW;
          else begin
            rd++;
            m = MODE_INTENT;
            owner_q[idx] = req;
          end
        end
        OP_UPGRADE: begin
          if (m != MODE_INTENT) r.status = ST_NOT_HELD;
          else if (owner_q[idx] != req) r.status = ST_NOT_OWNER;
          else if (rd > 1) r.status = ST_RETRY;
          else begin
            rd = 0;
            m  = MODE_WRITE;
          end
        end
        default: begin
          case (m)
            MODE_FREE: r.status = ST_NOT_HELD;
            MODE_READ: begin
              if (rd > 0) rd--;
              if (rd == 0) begin
                m      = MODE_FREE;
                r.wake = WAKE_ONE;
              end
            end
            MODE_INTENT: begin
              if (rd > 0) rd--;
              if (rd == 0) begin
                m      = MODE_FREE;
                r.wake = WAKE_ALL;
              end else if (owner_q[idx] == req) begin
                m = MODE_READ;
              end
            end
            default: begin
              if (owner_q[idx] != req) r.status = ST_NOT_OWNER;
              else begin
                rd     = 0;
                m      = MODE_FREE;
                r.wake = WAKE_ALL;
              end
            end
          endcase
        end
      endcase
      mode_q[idx]    = m;
      readers_q[idx] = rd;
      r.mode  = m;
      r.count = rd[COUNT_W-1:0];
      reply_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [3:0] want, logic [3:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_reply(logic [STATUS_W-1:0] status, logic [MODE_W-1:0] mode,
                              logic [COUNT_W-1:0] count, logic [WAKE_W-1:0] wake);
      lock_reply_t r;
      replies_seen++;
      if (reply_q.size() == 0) begin
        $display("%0t: reply with none expected, expected nothing, got status %0d",
                 $time, status);
        mismatches++;
        return;
      end
      r = reply_q.pop_front();
      compare_field("status", 4'(r.status), 4'(status));
      compare_field("lock_mode", 4'(r.mode), 4'(mode));
      compare_field("reader_count", 4'(r.count), 4'(count));
      compare_field("wake", 4'(r.wake), 4'(wake));
    endfunction
  endclass

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                in_valid_i     = 1'b0;
  logic                in_stall_o;
  logic [OP_W-1:0]     op_i           = '0;
  logic [IDX_W-1:0]    lock_index_i   = '0;
  logic [REQ_W-1:0]    requester_id_i = '0;
  logic                out_valid_o;
  logic                out_stall_i    = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic [MODE_W-1:0]   lock_mode_o;
  logic [COUNT_W-1:0]  reader_count_o;
  logic [WAKE_W-1:0]   wake_o;

  lock_table_shadow shadow = new();
  int  items_sent = 0;
  int  hold_left  = 0;
  bit  hold_done  = 1'b0;

  upgradable_rw_lock_table dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .lock_index_i   (lock_index_i),
    .requester_id_i (requester_id_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .lock_mode_o    (lock_mode_o),
    .reader_count_o (reader_count_o),
    .wake_o         (wake_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // called at a falling edge, returns at the falling edge after the beat
  task automatic issue_request(op_e op, logic [IDX_W-1:0] idx, logic [REQ_W-1:0] req);
    bit calm;
    calm = (items_sent >= 600 && items_sent < 900) || hold_left > 0;
    if (!calm && $urandom_range(99) < 14) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 2)) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    op_i           <= op;
    lock_index_i   <= idx;
    requester_id_i <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    shadow.accept_request(op, idx, req);
    items_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [IDX_W-1:0] pick_lock();
    if ($urandom_range(9) < 7) return IDX_W'($urandom_range(3));
    return IDX_W'($urandom_range(LOCK_COUNT - 1));
  endfunction

  task automatic run_upgrade_cycle();
    logic [IDX_W-1:0] l;
    logic [REQ_W-1:0] r;
    int               n;
    l = pick_lock();
    r = REQ_W'($urandom);
    n = $urandom_range(0, 2);
    issue_request(OP_INTENT, l, r);
    repeat (n) issue_request(OP_READ, l, REQ_W'($urandom));
    if ($urandom_range(3) == 0) issue_request(OP_UPGRADE, l, REQ_W'($urandom));
    repeat (n) issue_request(OP_UNLOCK, l, REQ_W'($urandom));
    issue_request(OP_UPGRADE, l, r);
    if ($urandom_range(3) == 0) issue_request(OP_READ, l, REQ_W'($urandom));
    issue_request(OP_UNLOCK, l, r);
  endtask

  task automatic run_fill();
    logic [IDX_W-1:0] l;
    int               n;
    l = pick_lock();
    n = $urandom_range(12, 17);
    repeat (n) issue_request(($urandom_range(7) == 0) ? OP_INTENT : OP_READ, l,
                             REQ_W'($urandom));
    repeat (n) issue_request(OP_UNLOCK, l, REQ_W'($urandom));
  endtask

  // receiver: random stalls, a calm window, and one long hold-off
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (!hold_done && shadow.replies_seen >= 300) begin
        hold_done = 1'b1;
        hold_left = 150;
        out_stall_i <= 1'b1;
      end else if (shadow.replies_seen >= 1000 && shadow.replies_seen < 1300) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < 14);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      shadow.check_reply(status_o, lock_mode_o, reader_count_o, wake_o);
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("[upgradable_rw_lock_table] ERROR");
    $finish;
  end

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: refusals, upgrade path, non-owner release, owner release
    issue_request(OP_UNLOCK, 4'd0, 4'd0);
    issue_request(OP_UPGRADE, 4'd0, 4'd0);
    issue_request(OP_READ, 4'd0, 4'd1);
    issue_request(OP_INTENT, 4'd0, 4'd2);
    issue_request(OP_INTENT, 4'd0, 4'd3);
    issue_request(OP_UPGRADE, 4'd0, 4'd3);
    issue_request(OP_UPGRADE, 4'd0, 4'd2);
    issue_request(OP_UNLOCK, 4'd0, 4'd5);
    issue_request(OP_UPGRADE, 4'd0, 4'd2);
    issue_request(OP_READ, 4'd0, 4'd1);
    issue_request(OP_INTENT, 4'd0, 4'd1);
    issue_request(OP_UNLOCK, 4'd0, 4'd1);
    issue_request(OP_UNLOCK, 4'd0, 4'd2);
    issue_request(OP_INTENT, 4'd15, 4'd15);
    issue_request(OP_READ, 4'd15, 4'd0);
    issue_request(OP_UNLOCK, 4'd15, 4'd15);
    issue_request(OP_UNLOCK, 4'd15, 4'd0);
    issue_request(OP_INTENT, 4'd3, 4'd9);
    issue_request(OP_UNLOCK, 4'd3, 4'd4);
    issue_request(OP_UNLOCK, 4'd3, 4'd9);

    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(9))
        0, 1, 2, 3: run_upgrade_cycle();
        4, 5:       run_fill();
        default: begin
          repeat ($urandom_range(1, 3))
            issue_request(op_e'($urandom_range(3)), IDX_W'($urandom), REQ_W'($urandom));
        end
      endcase
    end
    in_valid_i <= 1'b0;

    while (shadow.pending() != 0) @(posedge clk_i);
    repeat (8) @(negedge clk_i);
    if (shadow.mismatches == 0 && shadow.pending() == 0) begin
      $display("[upgradable_rw_lock_table] OK");
    end else begin
      $display("[upgradable_rw_lock_table] ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/urwl_pkg.sv
src/urwl_datapath.sv
src/urwl_ctrl.sv
src/upgradable_rw_lock_table.sv
verif/tb_upgradable_rw_lock_table.sv
